// ===== rtl/core/dwtr_pkg.sv =====
// shared types, constants and sine table function for the trajectory rollout block
package dwtr_pkg;

    localparam int MAX_STEPS_DEF  = 63;
    localparam int SINE_DEPTH_DEF = 256;

    localparam logic [2:0] REG_TIME_STEP  = 3'd0;
    localparam logic [2:0] REG_STEP_COUNT = 3'd1;
    localparam logic [2:0] REG_LIN_MAX    = 3'd2;
    localparam logic [2:0] REG_LIN_MIN    = 3'd3;
    localparam logic [2:0] REG_LIN_ACC    = 3'd4;
    localparam logic [2:0] REG_TURN_MAX   = 3'd5;
    localparam logic [2:0] REG_TURN_ACC   = 3'd6;

    // mul unit operation select
    typedef enum logic [2:0] {
        OP_DL  = 3'd0,
        OP_DA  = 3'd1,
        OP_VC  = 3'd2,
        OP_VS  = 3'd3,
        OP_XDT = 3'd4,
        OP_YDT = 3'd5,
        OP_WDT = 3'd6
    } mul_op_t;

    // one sine table entry (unsigned Q16), taylor series in Q30
    function automatic logic [16:0] sine_entry(input int unsigned k, input int unsigned depth);
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] t;
        logic signed [63:0] sum;
        logic [63:0] r;
        a   = (64'd1686629713 * 64'(k)) / 64'(depth);
        a2  = (a * a) >> 30;
        t   = a;
        sum = $signed(a);
        for (int n = 1; n <= 7; n++) begin
            t = ((t * a2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) sum = sum - $signed(t);
            else sum = sum + $signed(t);
        end
        if (sum < 0) sum = 0;
        r = (64'(sum) + 64'd8192) >> 14;
        return r[16:0];
    endfunction

endpackage

// ===== rtl/core/dwtr_sine.sv =====
// quarter-wave sine lookup with registered output
module dwtr_sine import dwtr_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic        [15:0] angle,
    output logic signed [17:0] sine_reg
);
    localparam int IW = $clog2(SINE_TABLE_DEPTH) + 1;

    logic [16:0]   tab [SINE_TABLE_DEPTH+1];
    logic [1:0]    quad;
    logic [14:0]   off;
    logic [40:0]   scaled;
    logic [IW-1:0] idx;
    logic signed [17:0] sine_next;

    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_tab
        assign tab[g] = sine_entry(g, SINE_TABLE_DEPTH);
    end

    always_comb begin
        quad = angle[15:14];
        off  = {1'b0, angle[13:0]};
        if (quad[0]) off = 15'd16384 - off;
        scaled = (41'(off) * 41'(SINE_TABLE_DEPTH)) >> 14;
        idx = scaled[IW-1:0];
        sine_next = $signed({1'b0, tab[idx]});
        if (quad[1]) sine_next = -sine_next;
    end

    always_ff @(posedge aclk) begin
        sine_reg <= sine_next;
    end
endmodule

// ===== rtl/core/dwtr_mul.sv =====
// shared registered multiplier with operand select
module dwtr_mul import dwtr_pkg::*; (
    input  logic               aclk,
    input  mul_op_t            op,
    input  logic        [15:0] dt,
    input  logic        [21:0] lin_acc,
    input  logic        [20:0] turn_acc,
    input  logic signed [20:0] vl,
    input  logic signed [19:0] va,
    input  logic signed [17:0] trig,
    input  logic signed [38:0] prod_in,
    output logic signed [55:0] prod_reg
);
    logic signed [39:0] a_op;
    logic signed [16:0] b_op;
    logic signed [55:0] prod_next;

    always_comb begin
        a_op = 40'sd0;
        b_op = $signed({1'b0, dt});
        unique case (op) inside
            OP_DL:  a_op = $signed(40'(lin_acc));
            OP_DA:  a_op = $signed(40'(turn_acc));
            OP_VC, OP_VS: begin
                a_op = 40'(vl);
                b_op = trig[16:0];
            end
            OP_XDT, OP_YDT: a_op = 40'(prod_in);
            OP_WDT: a_op = 40'(va);
            default: a_op = 40'sd0;
        endcase
        if (op == OP_VC || op == OP_VS) prod_next = 56'(a_op) * 56'(trig);
        else prod_next = 56'(a_op) * 56'(b_op);
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end
endmodule

// ===== rtl/core/dynamic_window_trajectory_rollout.sv =====
// top level: dynamic window check and unicycle rollout sequencer
// Usage:
//   s_axis carries one candidate per beat; tdata fields, low bit first:
//   start_x, start_y, start_heading, cur_lin, cur_ang, cand_lin, cand_ang.
//   m_axis carries one pose per beat; tdata: point_x, point_y,
//   point_heading, step_index; tuser: reachable; tlast marks the final pose.
//   Configuration is written by cfg_wr_en/cfg_addr/cfg_wdata while idle; the block itself does not enforce idle.
// Sequencing:
//   the window check runs two products through the shared multiplier
//   (states DL, DA), then the compare (CHK), after which the start pose beat
//   is offered. Each rolled-out step runs two sine lookups and five products
//   through the one multiplier (states SC, SS, MVC, MVS, MX, MY, MW, MH),
//   then its pose beat; an unreachable candidate gives only the start beat.
//   Receiver stalls hold the sequencer. s_axis_tready is high only
//   while no candidate is in work.
// Reset:
//   synchronous active-low aresetn returns the configuration, pose and output
//   registers to defaults and the sequencer to idle. A stalled receiver holds
//   the current pose beat and the sequencer waits.
module dynamic_window_trajectory_rollout import dwtr_pkg::*; #(
    parameter int MAX_STEPS        = MAX_STEPS_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // start_x, start_y, start_heading, cur_lin, cur_ang, cand_lin, cand_ang, pad
    input  logic [167:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // point_x, point_y, point_heading, step_index, pad
    output logic [87:0]  m_axis_tdata,
    // reachable
    output logic         m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_addr,
    input  logic [21:0]  cfg_wdata
);
    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_DL    = 13'b0000000000010,
        ST_DA    = 13'b0000000000100,
        ST_CHK   = 13'b0000000001000,
        ST_EMIT  = 13'b0000000010000,
        ST_SC    = 13'b0000000100000,
        ST_SS    = 13'b0000001000000,
        ST_MVC   = 13'b0000010000000,
        ST_MVS   = 13'b0000100000000,
        ST_MX    = 13'b0001000000000,
        ST_MY    = 13'b0010000000000,
        ST_MW    = 13'b0100000000000,
        ST_MH    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] time_step_reg;
    logic [5:0]  step_count_reg;
    logic [20:0] lin_max_reg, lin_min_reg;
    logic [21:0] lin_acc_reg;
    logic [18:0] turn_max_reg;
    logic [20:0] turn_acc_reg;

    logic signed [31:0] sim_x_reg, sim_y_reg;
    logic [15:0] sim_heading_reg;
    logic [5:0]  step_counter_reg, nsteps_reg;
    logic signed [20:0] held_lin_reg, cur_lin_reg;
    logic signed [19:0] held_ang_reg, cur_ang_reg;
    logic signed [23:0] dl_reg;
    logic signed [38:0] vtrig_reg;
    logic signed [17:0] cos_reg;
    logic        out_valid_reg, out_last_reg, out_reach_reg;
    logic        unreach_reg;

    logic signed [17:0] sine_reg;
    logic signed [55:0] prod_reg;
    logic [15:0] sine_angle;
    mul_op_t     op;

    logic signed [23:0] lhi, llo, ahi, alo, vl_w, va_w, da_w;
    logic signed [32:0] sum_x, sum_y;
    logic signed [56:0] rnd;
    logic signed [31:0] sat_v;
    logic [5:0]  cnt_n;
    logic signed [24:0] rnd_h;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_reach_reg;
    assign m_axis_tdata  = unreach_reg ? 88'd0 :
        {2'b00, step_counter_reg, sim_heading_reg, sim_y_reg, sim_x_reg};

    assign sine_angle = (state_reg == ST_SC) ? sim_heading_reg + 16'd16384 : sim_heading_reg;

    always_comb begin
        unique case (state_reg)
            ST_DL:   op = OP_DL;
            ST_DA:   op = OP_DA;
            ST_MVC:  op = OP_VC;
            ST_MVS:  op = OP_VS;
            ST_MX:   op = OP_XDT;
            ST_MY:   op = OP_YDT;
            default: op = OP_WDT;
        endcase
    end

    dwtr_sine #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sine (
        .aclk(aclk), .angle(sine_angle), .sine_reg(sine_reg)
    );

    dwtr_mul u_mul (
        .aclk(aclk), .op(op), .dt(time_step_reg), .lin_acc(lin_acc_reg),
        .turn_acc(turn_acc_reg), .vl(held_lin_reg), .va(held_ang_reg),
        .trig((state_reg == ST_MVC) ? cos_reg : sine_reg),
        .prod_in(vtrig_reg), .prod_reg(prod_reg)
    );

    always_comb begin
        // angular slack comes straight from the multiplier in the check cycle
        da_w = $signed({2'b00, prod_reg[37:16]});
        lhi = 24'(cur_lin_reg) + dl_reg;
        if ($signed(24'($signed(lin_max_reg))) < lhi) lhi = 24'($signed(lin_max_reg));
        llo = 24'(cur_lin_reg) - dl_reg;
        if ($signed(24'($signed(lin_min_reg))) > llo) llo = 24'($signed(lin_min_reg));
        ahi = 24'(cur_ang_reg) + da_w;
        if ($signed({5'd0, turn_max_reg}) < ahi) ahi = {5'd0, turn_max_reg};
        alo = 24'(cur_ang_reg) - da_w;
        if (-$signed({5'd0, turn_max_reg}) > alo) alo = -$signed({5'd0, turn_max_reg});
        vl_w = 24'(held_lin_reg);
        va_w = 24'(held_ang_reg);
        rnd  = (57'(prod_reg) + 57'sd2147483648) >>> 32;
        rnd_h = 25'((57'(prod_reg) + 57'sd32768) >>> 16);
        sum_x = 33'(sim_x_reg) + 33'(rnd);
        sum_y = 33'(sim_y_reg) + 33'(rnd);
        sat_v = (state_reg == ST_MY) ? sum_x[31:0] : sum_y[31:0];
        if (state_reg == ST_MY) begin
            if (sum_x > 33'sd2147483647) sat_v = 32'h7fffffff;
            else if (sum_x < -33'sd2147483648) sat_v = 32'h80000000;
        end else begin
            if (sum_y > 33'sd2147483647) sat_v = 32'h7fffffff;
            else if (sum_y < -33'sd2147483648) sat_v = 32'h80000000;
        end
        cnt_n = (int'(step_count_reg) > MAX_STEPS) ? 6'(MAX_STEPS) : step_count_reg;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_axis_tvalid) state_next = ST_DL;
            ST_DL:   state_next = ST_DA;
            ST_DA:   state_next = ST_CHK;
            ST_CHK:  state_next = ST_EMIT;
            ST_EMIT: if (m_axis_tready) begin
                if (out_last_reg) state_next = ST_IDLE;
                else state_next = ST_SC;
            end
            ST_SC:   state_next = ST_SS;
            ST_SS:   state_next = ST_MVC;
            ST_MVC:  state_next = ST_MVS;
            ST_MVS:  state_next = ST_MX;
            ST_MX:   state_next = ST_MY;
            ST_MY:   state_next = ST_MW;
            ST_MW:   state_next = ST_MH;
            ST_MH:   state_next = ST_EMIT;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            time_step_reg    <= 16'd6554;
            step_count_reg   <= 6'd30;
            lin_max_reg      <= 21'd65536;
            lin_min_reg      <= 21'd0;
            lin_acc_reg      <= 22'd32768;
            turn_max_reg     <= 19'd16384;
            turn_acc_reg     <= 21'd16384;
            out_valid_reg    <= 1'b0;
            out_last_reg     <= 1'b0;
            out_reach_reg    <= 1'b0;
            unreach_reg      <= 1'b0;
            sim_x_reg        <= '0;
            sim_y_reg        <= '0;
            sim_heading_reg  <= '0;
            step_counter_reg <= '0;
            held_lin_reg     <= '0;
            held_ang_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_TIME_STEP:  time_step_reg  <= cfg_wdata[15:0];
                    REG_STEP_COUNT: step_count_reg <= cfg_wdata[5:0];
                    REG_LIN_MAX:    lin_max_reg    <= cfg_wdata[20:0];
                    REG_LIN_MIN:    lin_min_reg    <= cfg_wdata[20:0];
                    REG_LIN_ACC:    lin_acc_reg    <= cfg_wdata;
                    REG_TURN_MAX:   turn_max_reg   <= cfg_wdata[18:0];
                    REG_TURN_ACC:   turn_acc_reg   <= cfg_wdata[20:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: if (s_axis_tvalid) begin
                    sim_x_reg    <= s_axis_tdata[31:0];
                    sim_y_reg    <= s_axis_tdata[63:32];
                    sim_heading_reg <= s_axis_tdata[79:64];
                    cur_lin_reg  <= s_axis_tdata[100:80];
                    cur_ang_reg  <= s_axis_tdata[120:101];
                    held_lin_reg <= s_axis_tdata[141:121];
                    held_ang_reg <= s_axis_tdata[161:142];
                end
                ST_DA: dl_reg <= {1'b0, prod_reg[38:16]};
                ST_CHK: out_valid_reg <= 1'b1;
                ST_EMIT: if (m_axis_tready) out_valid_reg <= 1'b0;
                ST_SC:   ;
                ST_SS:   cos_reg <= sine_reg;
                ST_MVC:  ;
                ST_MVS:  vtrig_reg <= prod_reg[38:0];
                ST_MX:   vtrig_reg <= prod_reg[38:0];
                ST_MY:   sim_x_reg <= sat_v;
                ST_MW:   sim_y_reg <= sat_v;
                ST_MH: begin
                    sim_heading_reg <= sim_heading_reg + rnd_h[15:0];
                    step_counter_reg <= step_counter_reg + 6'd1;
                    out_valid_reg <= 1'b1;
                    out_last_reg <= (step_counter_reg + 6'd1 == nsteps_reg);
                end
                default: ;
            endcase
            if (state_reg == ST_CHK) begin
                if (vl_w > lhi || vl_w < llo || va_w > ahi || va_w < alo) begin
                    unreach_reg   <= 1'b1;
                    out_last_reg  <= 1'b1;
                    out_reach_reg <= 1'b0;
                end else begin
                    unreach_reg      <= 1'b0;
                    out_reach_reg    <= 1'b1;
                    out_last_reg     <= (cnt_n == 6'd0);
                    nsteps_reg       <= cnt_n;
                    step_counter_reg <= 6'd0;
                end
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> state_reg == ST_EMIT)
        else $error("output valid outside emit");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tlast && m_axis_tready) |=> s_axis_tready)
        else $error("not idle after last beat");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
        else $error("unreachable beat not last");
endmodule
